@@ src/fap_pkg.sv @@
// Shared widths, configuration codes, structs and helpers of the framed ASCII field parser.
package fap_pkg;

  localparam int BYTE_W      = 8;
  localparam int VALUE_W     = 32;
  localparam int FIELD_W     = 5;
  localparam int LEN_W       = 3;
  localparam int PATTERN_W   = 32;
  localparam int KINDS_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int DEF_MAX_FIELDS      = 16;
  localparam int DEF_MAX_DELIM_BYTES = 4;

  localparam logic [PATTERN_W-1:0] RST_HEAD_PATTERN    = 32'd0;
  localparam logic [LEN_W-1:0]     RST_HEAD_LENGTH     = 3'd0;
  localparam logic [PATTERN_W-1:0] RST_DIVIDER_PATTERN = 32'd44;
  localparam logic [LEN_W-1:0]     RST_DIVIDER_LENGTH  = 3'd1;
  localparam logic [PATTERN_W-1:0] RST_TAIL_PATTERN    = 32'd10;
  localparam logic [LEN_W-1:0]     RST_TAIL_LENGTH     = 3'd1;
  localparam logic [KINDS_W-1:0]   RST_FIELD_KINDS     = 16'd0;
  localparam logic [FIELD_W-1:0]   RST_FIELD_COUNT     = 5'd0;

  localparam logic [BYTE_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] ASCII_POINT = 8'h2E;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEAD_PATTERN    = 3'd0,
    REG_HEAD_LENGTH     = 3'd1,
    REG_DIVIDER_PATTERN = 3'd2,
    REG_DIVIDER_LENGTH  = 3'd3,
    REG_TAIL_PATTERN    = 3'd4,
    REG_TAIL_LENGTH     = 3'd5,
    REG_FIELD_KINDS     = 3'd6,
    REG_FIELD_COUNT     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] head_pattern;
    logic [LEN_W-1:0]     head_length;
    logic [PATTERN_W-1:0] divider_pattern;
    logic [LEN_W-1:0]     divider_length;
    logic [PATTERN_W-1:0] tail_pattern;
    logic [LEN_W-1:0]     tail_length;
    logic [KINDS_W-1:0]   field_kinds;
    logic [FIELD_W-1:0]   field_count;
  } cfg_t;

  typedef struct packed {
    logic                      emit;
    logic                      has_value;
    logic [FIELD_W-1:0]        field_index;
    logic signed [VALUE_W-1:0] field_value;
    logic                      frame_end;
  } result_t;

  // Byte p of a pattern register; positions past the register read as zero.
  function automatic logic [BYTE_W-1:0] pat_byte(logic [PATTERN_W-1:0] pat,
                                                 logic [LEN_W-1:0] p);
    logic [BYTE_W-1:0] r;
    if (p[2]) begin
      r = '0;
    end else begin
      r = pat[{p[1:0], 3'b000} +: BYTE_W];
    end
    return r;
  endfunction

endpackage

@@ src/fap_if.sv @@
// Valid/ready channel interfaces for the input bytes and the parse results.
interface fap_byte_if;
  logic                      valid;
  logic                      ready;
  logic [fap_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface fap_result_if;
  logic                               valid;
  logic                               ready;
  logic                               has_value;
  logic [fap_pkg::FIELD_W-1:0]        field_index;
  logic signed [fap_pkg::VALUE_W-1:0] field_value;
  logic                               frame_end;

  modport source (output valid, output has_value, output field_index,
                  output field_value, output frame_end, input ready);
  modport sink   (input valid, input has_value, input field_index,
                  input field_value, input frame_end, output ready);
endinterface

@@ src/fap_match.sv @@
// One step of a naive restart string matcher over a four byte pattern register.
module fap_match (
  input  logic [fap_pkg::LEN_W-1:0]     pos,
  input  logic [fap_pkg::PATTERN_W-1:0] pattern,
  input  logic [fap_pkg::LEN_W-1:0]     len,
  input  logic [fap_pkg::BYTE_W-1:0]    data,
  output logic                          hit,
  output logic [fap_pkg::LEN_W-1:0]     pos_next
);
  import fap_pkg::*;

  logic [LEN_W:0] advanced;

  always_comb begin
    if (pat_byte(pattern, pos) == data) begin
      advanced = {1'b0, pos} + 4'd1;
    end else if (pat_byte(pattern, 3'd0) == data) begin
      advanced = 4'd1;
    end else begin
      advanced = 4'd0;
    end
    hit      = advanced >= {1'b0, len};
    pos_next = hit ? '0 : advanced[LEN_W-1:0];
  end

endmodule

@@ src/fap_core.sv @@
// Parse state of the framed ASCII field parser and its per-byte update.
module fap_core #(
  parameter int MAX_FIELDS      = fap_pkg::DEF_MAX_FIELDS,
  parameter int MAX_DELIM_BYTES = fap_pkg::DEF_MAX_DELIM_BYTES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [fap_pkg::BYTE_W-1:0] data,
  input  fap_pkg::cfg_t              cfg,
  output fap_pkg::result_t           res
);
  import fap_pkg::*;

  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] v, logic min_one);
    logic [LEN_W-1:0] r;
    r = (min_one && v == '0) ? LEN_W'(1) : v;
    if ({1'b0, r} > (LEN_W + 1)'(MAX_DELIM_BYTES)) begin
      r = LEN_W'(MAX_DELIM_BYTES);
    end
    return r;
  endfunction

  function automatic logic is_int_field(logic [FIELD_W-1:0] f, logic [FIELD_W-1:0] eff,
                                        logic [KINDS_W-1:0] kinds);
    return (f < eff) && !f[FIELD_W-1] && kinds[f[FIELD_W-2:0]];
  endfunction

  logic                      in_record;
  logic [LEN_W-1:0]          hd_pos;
  logic [LEN_W-1:0]          tl_pos;
  logic [FIELD_W-1:0]        cur_field;
  logic                      neg;
  logic [VALUE_W-1:0]        acc;
  logic [VALUE_W-1:0]        held;
  logic                      held_valid;

  logic                      in_record_next;
  logic [LEN_W-1:0]          hd_pos_next;
  logic [LEN_W-1:0]          tl_pos_next;
  logic [FIELD_W-1:0]        cur_field_next;
  logic                      neg_next;
  logic [VALUE_W-1:0]        acc_next;
  logic [VALUE_W-1:0]        held_next;
  logic                      held_valid_next;

  logic [LEN_W-1:0]          hlen, dlen, tlen;
  logic [FIELD_W-1:0]        eff_count;
  logic                      seek_head;
  logic [LEN_W-1:0]          a_pos;
  logic [PATTERN_W-1:0]      a_pattern;
  logic [LEN_W-1:0]          a_len;
  logic                      a_hit;
  logic [LEN_W-1:0]          a_pos_next;
  logic [LEN_W-1:0]          t_pos;
  logic                      t_hit;
  logic [LEN_W-1:0]          t_pos_next;

  assign hlen      = clamp_len(cfg.head_length, 1'b0);
  assign dlen      = clamp_len(cfg.divider_length, 1'b1);
  assign tlen      = clamp_len(cfg.tail_length, 1'b1);
  assign eff_count = ({1'b0, cfg.field_count} > (FIELD_W + 1)'(MAX_FIELDS)) ?
                     FIELD_W'(MAX_FIELDS) : cfg.field_count;
  assign seek_head = !in_record && (hlen != '0);

  // The head and the divider share one position register.
  assign a_pos     = (in_record || seek_head) ? hd_pos : '0;
  assign a_pattern = seek_head ? cfg.head_pattern : cfg.divider_pattern;
  assign a_len     = seek_head ? hlen : dlen;
  assign t_pos     = in_record ? tl_pos : '0;

  fap_match u_head_div (
    .pos      (a_pos),
    .pattern  (a_pattern),
    .len      (a_len),
    .data     (data),
    .hit      (a_hit),
    .pos_next (a_pos_next)
  );

  fap_match u_tail (
    .pos      (t_pos),
    .pattern  (cfg.tail_pattern),
    .len      (tlen),
    .data     (data),
    .hit      (t_hit),
    .pos_next (t_pos_next)
  );

  always_comb begin
    logic [FIELD_W-1:0] cf;
    logic               sg;
    logic [VALUE_W-1:0] ac;
    logic [VALUE_W-1:0] hv_val;
    logic               hv;
    logic               is_int;
    logic               have;
    logic               fin;
    logic [FIELD_W-1:0] idx;
    logic [VALUE_W-1:0] val;
    logic [LEN_W-1:0]   tp;

    in_record_next  = in_record;
    hd_pos_next     = hd_pos;
    tl_pos_next     = tl_pos;
    cur_field_next  = cur_field;
    neg_next        = neg;
    acc_next        = acc;
    held_next       = held;
    held_valid_next = held_valid;
    res             = '0;

    cf     = in_record ? cur_field : '0;
    sg     = in_record ? neg : 1'b0;
    ac     = in_record ? acc : '0;
    hv_val = in_record ? held : '0;
    hv     = in_record ? held_valid : 1'b0;
    is_int = is_int_field(cf, eff_count, cfg.field_kinds);
    have   = 1'b0;
    fin    = 1'b0;
    idx    = '0;
    val    = '0;
    tp     = t_pos;

    if (seek_head) begin
      if (a_hit) begin
        in_record_next  = 1'b1;
        hd_pos_next     = '0;
        tl_pos_next     = '0;
        cur_field_next  = '0;
        neg_next        = 1'b0;
        acc_next        = '0;
        held_next       = '0;
        held_valid_next = 1'b0;
      end else begin
        hd_pos_next = a_pos_next;
      end
    end else begin
      if (is_int) begin
        if (!sg && data == ASCII_MINUS) begin
          sg = 1'b1;
        end else if (data >= ASCII_ZERO && data <= ASCII_NINE) begin
          ac = (ac << 3) + (ac << 1) + VALUE_W'(data[3:0]);
        end else if (data == pat_byte(cfg.tail_pattern, 3'd0) ||
                     data == pat_byte(cfg.divider_pattern, 3'd0) ||
                     data == ASCII_POINT) begin
          hv_val = sg ? (VALUE_W'(0) - ac) : ac;
          hv     = 1'b1;
          ac     = '0;
          sg     = 1'b0;
        end
      end

      if (a_hit) begin
        if (is_int && hv) begin
          have = 1'b1;
          idx  = cf;
          val  = hv_val;
        end
        hv = 1'b0;
        if (cf >= eff_count) begin
          fin = 1'b1;
        end else begin
          cf = cf + FIELD_W'(1);
        end
      end

      if (!fin) begin
        tp = t_pos_next;
        if (t_hit) begin
          if (is_int_field(cf, eff_count, cfg.field_kinds) && hv) begin
            have = 1'b1;
            idx  = cf;
            val  = hv_val;
          end
          fin = 1'b1;
        end
      end

      if (fin) begin
        in_record_next  = 1'b0;
        hd_pos_next     = '0;
        tl_pos_next     = '0;
        cur_field_next  = '0;
        neg_next        = 1'b0;
        acc_next        = '0;
        held_next       = '0;
        held_valid_next = 1'b0;
      end else begin
        in_record_next  = 1'b1;
        hd_pos_next     = a_pos_next;
        tl_pos_next     = tp;
        cur_field_next  = cf;
        neg_next        = sg;
        acc_next        = ac;
        held_next       = hv_val;
        held_valid_next = hv;
      end

      res.emit        = have || fin;
      res.has_value   = have;
      res.field_index = idx;
      res.field_value = val;
      res.frame_end   = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_record  <= 1'b0;
      hd_pos     <= '0;
      tl_pos     <= '0;
      cur_field  <= '0;
      neg        <= 1'b0;
      acc        <= '0;
      held       <= '0;
      held_valid <= 1'b0;
    end else if (step) begin
      in_record  <= in_record_next;
      hd_pos     <= hd_pos_next;
      tl_pos     <= tl_pos_next;
      cur_field  <= cur_field_next;
      neg        <= neg_next;
      acc        <= acc_next;
      held       <= held_next;
      held_valid <= held_valid_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_leaves_record: assert property (@(posedge clk) disable iff (rst)
    step && res.frame_end |=> !in_record)
    else $error("record still open after a frame end");
  a_field_bounded: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cur_field} <= (FIELD_W + 1)'(MAX_FIELDS))
    else $error("current field beyond the field limit");
  a_seek_silent: assert property (@(posedge clk) disable iff (rst)
    seek_head |-> !res.emit)
    else $error("result produced while hunting for the head");
`endif

endmodule

@@ src/framed_ascii_integer_field_parser.sv @@
// Top level of the framed ASCII integer field parser: config registers, input and result stages.
// The parser takes one ASCII byte per transfer and sustains one byte per clock cycle while results are taken.
// A byte accepted is held in the input register, runs through the combinational parse
// update once the result register can take its result, and that result then lands in
// the result register, from where it is offered on the output. The parse loop (match
// compares, one times-ten add, sign handling) is combinational and sets the byte rate.
// Bytes that cause no result leave nothing on the output. While a result waits on the
// output, the input register still takes one more byte; further bytes wait until the
// result is taken.
module framed_ascii_integer_field_parser #(
  parameter int MAX_FIELDS      = fap_pkg::DEF_MAX_FIELDS,
  parameter int MAX_DELIM_BYTES = fap_pkg::DEF_MAX_DELIM_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fap_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fap_pkg::CFG_DATA_W-1:0]  cfg_data,
  fap_byte_if.sink                        in_ch,
  fap_result_if.source                    out_ch
);
  import fap_pkg::*;

  // Configuration registers. The user must make writes only while the parser is idle,
  // which the block itself does not enforce; the parse logic reads them directly.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_pattern    <= RST_HEAD_PATTERN;
      cfg.head_length     <= RST_HEAD_LENGTH;
      cfg.divider_pattern <= RST_DIVIDER_PATTERN;
      cfg.divider_length  <= RST_DIVIDER_LENGTH;
      cfg.tail_pattern    <= RST_TAIL_PATTERN;
      cfg.tail_length     <= RST_TAIL_LENGTH;
      cfg.field_kinds     <= RST_FIELD_KINDS;
      cfg.field_count     <= RST_FIELD_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEAD_PATTERN:    cfg.head_pattern    <= cfg_data[PATTERN_W-1:0];
        REG_HEAD_LENGTH:     cfg.head_length     <= cfg_data[LEN_W-1:0];
        REG_DIVIDER_PATTERN: cfg.divider_pattern <= cfg_data[PATTERN_W-1:0];
        REG_DIVIDER_LENGTH:  cfg.divider_length  <= cfg_data[LEN_W-1:0];
        REG_TAIL_PATTERN:    cfg.tail_pattern    <= cfg_data[PATTERN_W-1:0];
        REG_TAIL_LENGTH:     cfg.tail_length     <= cfg_data[LEN_W-1:0];
        REG_FIELD_KINDS:     cfg.field_kinds     <= cfg_data[KINDS_W-1:0];
        REG_FIELD_COUNT:     cfg.field_count     <= cfg_data[FIELD_W-1:0];
      endcase
    end
  end

  // Input register. The held byte is parsed in the cycle where the result
  // register can take whatever it produces, which is whenever the result
  // register is empty or its current content is being transferred out.
  logic                in_valid_q;
  logic [BYTE_W-1:0]   byte_q;
  logic                advance;
  logic                step;
  result_t             res;

  assign advance     = !out_ch.valid || out_ch.ready;
  assign step        = in_valid_q && advance;
  assign in_ch.ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_q <= in_ch.in_byte;
    end
  end

  // The parse state and its per-byte update live in the core.
  fap_core #(
    .MAX_FIELDS      (MAX_FIELDS),
    .MAX_DELIM_BYTES (MAX_DELIM_BYTES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .data (byte_q),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register. A parsed byte with a result loads it; otherwise a
  // completed transfer empties the register.
  logic out_valid_q;

  assign out_ch.valid = out_valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (step && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_ch.has_value   <= res.has_value;
      out_ch.field_index <= res.field_index;
      out_ch.field_value <= res.field_value;
      out_ch.frame_end   <= res.frame_end;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_not_empty: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.has_value || out_ch.frame_end))
    else $error("result carries neither a value nor a frame end");
  a_no_value_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.has_value |->
      (out_ch.field_index == '0 && out_ch.field_value == '0))
    else $error("result without a value has nonzero index or value");
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.has_value |->
      {1'b0, out_ch.field_index} < (FIELD_W + 1)'(MAX_FIELDS))
    else $error("reported field index beyond the field limit");
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !advance |=> in_valid_q && $stable(byte_q))
    else $error("held byte lost while the result stage was stalled");
`endif

endmodule
